FILE: src/g3ruh_descrambler_with_soft_dcd_assert.svh
// Assertion macros shared by the descrambler modules.
`ifndef G3RUH_DESCRAMBLER_WITH_SOFT_DCD_ASSERT_SVH
`define G3RUH_DESCRAMBLER_WITH_SOFT_DCD_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define G3DSC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// A condition in one cycle that implies a consequence in the next.
`define G3DSC_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

FILE: src/g3dsc_pkg.sv
`default_nettype none

package g3dsc_pkg;

   localparam int BURST_BITS  = 16;
   localparam int HIST_BITS   = 19;
   localparam int WIN_BITS    = 32;
   localparam int CNT_BITS    = 12;
   localparam int HOLD_BITS   = 10;
   localparam int PEN_BITS    = 11;
   localparam int SUM_BITS    = 17;
   localparam int STEP_BITS   = 5;
   localparam int ONES_BITS   = $clog2(BURST_BITS + 1);
   localparam int FLAG_BITS   = 8;
   localparam int FLAG_LOW    = 9;
   localparam int TAP_A       = 17;
   localparam int TAP_B       = 12;
   localparam int TAP_COUNT   = 6;
   localparam int CNT_MAX     = 2047;
   localparam int RELOAD_ADD  = 4;
   localparam int PENALTY_SUB = 10;
   localparam int DECAY       = 2;

   localparam logic [FLAG_BITS-1:0] FLAG_PATTERN   = 8'b0111_1110;
   localparam logic [HOLD_BITS-1:0] HOLD_BASE_INIT = 10'd400;

   typedef enum logic {
      CSR_SOFT_ENABLE = 1'b0,
      CSR_HOLD_BASE   = 1'b1
   } csr_index_type;

   // What the decode stage hands to the carrier merge stage for one item.
   typedef struct packed {
      logic                  soft_en;
      logic                  any_flag;
      logic [ONES_BITS-1:0]  ones_cnt;
      logic                  pin;
      logic [BURST_BITS-1:0] decoded;
   } stage_type;

endpackage

`default_nettype wire

FILE: src/g3ruh_descrambler_with_soft_dcd.sv
// Channel  Direction  Ports                                   Handshake
// req      in         req_line_bits, req_pin_carrier          req_valid / req_stall
// rsp      out        rsp_decoded_bits, rsp_carrier_present   rsp_valid / rsp_stall
// csr      in/out     psel, penable, pwrite, paddr, pwdata,   APB, pready tied high
//                     prdata, pready
//
// Each item passes two register stages: a decode stage of sixteen lanes and a
// carrier merge stage whose counter loop closes combinationally around its counter
// register. Its result is registered in the output register after the decode stage.
// One item is accepted per cycle while results are taken.
// Reset is synchronous and clears the history, window, counter and configuration.
// A stalled result holds the output register; the decode stage keeps accepting
// until it is also full, then req_stall rises.
`default_nettype none
`include "g3ruh_descrambler_with_soft_dcd_assert.svh"

module g3ruh_descrambler_with_soft_dcd
   import g3dsc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [BURST_BITS-1:0] req_line_bits,
   input  wire logic                  req_pin_carrier,

   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [BURST_BITS-1:0]      rsp_decoded_bits,
   output logic                       rsp_carrier_present,

   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [2:0]            paddr,
   input  wire logic [31:0]           pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);

   // Configuration registers. Register i sits at byte address 4*i, so paddr[2]
   // selects the register.
   logic                 soft_en_ff;
   logic [HOLD_BITS-1:0] hold_base_ff;
   csr_index_type        csr_index;
   logic                 csr_write;

   assign pready    = 1'b1;
   assign csr_index = csr_index_type'(paddr[2]);
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         soft_en_ff   <= 1'b0;
         hold_base_ff <= HOLD_BASE_INIT;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_SOFT_ENABLE: soft_en_ff   <= pwdata[0];
            CSR_HOLD_BASE:   hold_base_ff <= pwdata[HOLD_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         CSR_SOFT_ENABLE: prdata = {31'b0, soft_en_ff};
         CSR_HOLD_BASE:   prdata = {{(32-HOLD_BITS){1'b0}}, hold_base_ff};
         default:         prdata = '0;
      endcase
   end

   // Pipeline control. The decode stage fills whenever it is empty or moving on,
   // and it moves on whenever the output register is empty or being taken.
   logic a_valid_ff, a_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic b_free, a_free, req_accept, b_load;

   assign b_free     = !rsp_valid_ff || !rsp_stall;
   assign a_free     = !a_valid_ff || b_free;
   assign req_stall  = !a_free;
   assign req_accept = req_valid && a_free;
   assign b_load     = a_valid_ff && b_free;

   assign a_valid_in   = req_accept || (a_valid_ff && !b_free);
   assign rsp_valid_in = b_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // The line stream in time order: the 19 stored bits, oldest first, followed
   // by the new burst. Lane i sees its own bit at index i + HIST_BITS.
   localparam int STREAM_BITS = HIST_BITS + BURST_BITS;

   logic [HIST_BITS-1:0]   hist_ff, hist_in;
   logic [WIN_BITS-1:0]    window_ff, window_in;
   logic [STREAM_BITS-1:0] stream;
   logic [BURST_BITS-1:0]  word, flag_vec, ones_vec;

   always_comb begin
      stream[STREAM_BITS-1:HIST_BITS] = req_line_bits;
      for (int j = 0; j < HIST_BITS; j++) begin
         stream[HIST_BITS-1-j] = hist_ff[j];
         hist_in[j]            = stream[STREAM_BITS-1-j];
      end
   end

   // The window holds the previous word low and the new word high.
   assign window_in = {word, window_ff[WIN_BITS-1:BURST_BITS]};

   for (genvar i = 0; i < BURST_BITS; i++) begin : g_lane
      localparam int POS = HIST_BITS + i;
      logic [TAP_COUNT-1:0] taps;

      // Each tap pair is a differential decode at that delay.
      assign taps = {stream[POS], stream[POS-1],
                     stream[POS-TAP_B], stream[POS-TAP_B-1],
                     stream[POS-TAP_A], stream[POS-TAP_A-1]};

      g3dsc_lane u_lane (
         .taps     (taps),
         .win      (window_in[FLAG_LOW+i +: FLAG_BITS]),
         .data_bit (word[i]),
         .flag_hit (flag_vec[i]),
         .ones_hit (ones_vec[i])
      );
   end

   stage_type a_ff, a_in;

   always_comb begin
      a_in.soft_en  = soft_en_ff;
      a_in.any_flag = |flag_vec;
      a_in.ones_cnt = ONES_BITS'($countones(ones_vec));
      a_in.pin      = req_pin_carrier;
      a_in.decoded  = word;
   end

   // History advances with every accepted item; the window only advances in soft carrier mode.
   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff   <= '0;
         window_ff <= '0;
      end else if (req_accept) begin
         hist_ff <= hist_in;
         if (soft_en_ff) begin
            window_ff <= window_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         a_ff <= a_in;
      end
   end

   // Merge stage: in soft mode the flag and run results of all lanes update the counter.
   logic carrier_in;

   g3dsc_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .load       (b_load),
      .stage      (a_ff),
      .hold_base  (hold_base_ff),
      .carrier_in (carrier_in)
   );

   logic [BURST_BITS-1:0] rsp_decoded_ff;
   logic                  rsp_carrier_ff;

   always_ff @(posedge clock) begin
      if (b_load) begin
         rsp_decoded_ff <= a_ff.decoded;
         rsp_carrier_ff <= carrier_in;
      end
   end

   assign rsp_decoded_bits    = rsp_decoded_ff;
   assign rsp_carrier_present = rsp_carrier_ff;

   `G3DSC_ASSERT_NEXT(a_stage_kept, clock, reset, a_valid_ff && !b_free, a_valid_ff,
      "decode stage item dropped while output stalled")
   `G3DSC_ASSERT_NEXT(a_stage_moves, clock, reset, a_valid_ff && b_free, rsp_valid_ff,
      "decode stage item did not reach the output")
   `G3DSC_ASSERT_NEXT(a_pin_carrier, clock, reset, b_load && !a_ff.soft_en,
      rsp_carrier_present == $past(a_ff.pin), "hardware carrier not taken from the pin")

endmodule

`default_nettype wire

FILE: src/g3dsc_lane.sv
`default_nettype none

module g3dsc_lane
   import g3dsc_pkg::*;
(
   input  wire logic [TAP_COUNT-1:0] taps,
   input  wire logic [FLAG_BITS-1:0] win,
   output logic                      data_bit,
   output logic                      flag_hit,
   output logic                      ones_hit
);

   // The differential decode and the descrambler taps fold into one XOR;
   // the data bit is its inverse.
   assign data_bit = ~(^taps);
   assign flag_hit = (win == FLAG_PATTERN);
   assign ones_hit = &win;

endmodule

`default_nettype wire

FILE: src/g3dsc_cnt_lane.sv
`default_nettype none

module g3dsc_cnt_lane
   import g3dsc_pkg::*;
(
   input  wire logic [STEP_BITS-1:0]       step,
   input  wire logic signed [CNT_BITS-1:0] start,
   input  wire logic signed [PEN_BITS-1:0] penalty,
   output logic signed [SUM_BITS-1:0]      value
);

   logic signed [STEP_BITS:0]   step_s;
   logic signed [SUM_BITS-1:0]  prod;

   // Counter value after this many penalty steps, ignoring the stop rule.
   assign step_s = signed'({1'b0, step});
   assign prod   = SUM_BITS'(step_s) * SUM_BITS'(penalty);
   assign value  = SUM_BITS'(start) - prod;

endmodule

`default_nettype wire

FILE: src/g3dsc_merge.sv
`default_nettype none
`include "g3ruh_descrambler_with_soft_dcd_assert.svh"

module g3dsc_merge
   import g3dsc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire stage_type            stage,
   input  wire logic [HOLD_BITS-1:0] hold_base,
   output logic                      carrier_in
);

   logic signed [CNT_BITS-1:0] counter_ff;
   logic signed [CNT_BITS-1:0] counter_in;
   logic signed [CNT_BITS-1:0] reload;
   logic signed [PEN_BITS-1:0] penalty;
   logic signed [CNT_BITS-1:0] start;
   logic signed [SUM_BITS-1:0] value [0:BURST_BITS];
   logic [STEP_BITS-1:0]       steps_taken;
   logic signed [SUM_BITS-1:0] value_sel;
   logic signed [CNT_BITS-1:0] after_runs;

   assign reload  = signed'({{(CNT_BITS-HOLD_BITS){1'b0}}, hold_base} + CNT_BITS'(RELOAD_ADD));
   assign penalty = signed'({1'b0, hold_base} - PEN_BITS'(PENALTY_SUB));
   assign start   = stage.any_flag ? reload : counter_ff;
   assign value[0] = SUM_BITS'(start);

   // One lane per nonzero run count evaluates the counter after that many steps.
   for (genvar k = 1; k <= BURST_BITS; k++) begin : g_cnt
      g3dsc_cnt_lane u_cnt_lane (
         .step    (STEP_BITS'(k)),
         .start   (start),
         .penalty (penalty),
         .value   (value[k])
      );
   end

   // Steps stop at the first value that goes negative, or when the runs are used up.
   always_comb begin
      steps_taken = STEP_BITS'(stage.ones_cnt);
      for (int j = BURST_BITS; j >= 1; j--) begin
         if ((STEP_BITS'(j) <= STEP_BITS'(stage.ones_cnt)) && value[j][SUM_BITS-1]) begin
            steps_taken = STEP_BITS'(j);
         end
      end
   end

   assign value_sel = value[steps_taken];

   always_comb begin
      if (start[CNT_BITS-1]) begin
         after_runs = start;
      end else if (value_sel > SUM_BITS'(CNT_MAX)) begin
         after_runs = CNT_BITS'(CNT_MAX);
      end else begin
         after_runs = value_sel[CNT_BITS-1:0];
      end
   end

   always_comb begin
      if (after_runs[CNT_BITS-1]) begin
         counter_in = after_runs;
      end else begin
         counter_in = after_runs - CNT_BITS'(DECAY);
      end
   end

   assign carrier_in = stage.soft_en ? (!counter_in[CNT_BITS-1] && (counter_in != '0))
                                     : stage.pin;

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff <= '0;
      end else if (load && stage.soft_en) begin
         counter_ff <= counter_in;
      end
   end

   `G3DSC_ASSERT_NEXT(a_hw_holds, clock, reset, load && !stage.soft_en, $stable(counter_ff),
      "counter moved in hardware carrier mode")
   `G3DSC_ASSERT_NEXT(a_decay, clock, reset,
      load && stage.soft_en && !stage.any_flag && (stage.ones_cnt == '0) && !counter_ff[CNT_BITS-1],
      counter_ff == $past(counter_ff) - CNT_BITS'(DECAY), "quiet burst did not decay counter")
   `G3DSC_ASSERT_NEXT(a_flag_reload, clock, reset,
      load && stage.soft_en && stage.any_flag && (stage.ones_cnt == '0),
      counter_ff == $past(reload) - CNT_BITS'(DECAY), "flag did not reload counter")

endmodule

`default_nettype wire
